FILE: rtl/apc_pkg.sv
// shared types and constants of the alignment profile counter
`timescale 1ns / 1ps

package apc_pkg;

  // width of one count on the result channel
  localparam int OUT_W = 16;

  // count slots in one column word of the column memory
  localparam int SLOT_MATCH  = 0;
  localparam int SLOT_INSERT = 4;
  localparam int SLOT_STATE  = 8;
  localparam int SLOTS       = 11;

  // characters of interest
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_C = 8'h43;
  localparam logic [7:0] CH_UP_G = 8'h47;
  localparam logic [7:0] CH_UP_T = 8'h54;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_C = 8'h63;
  localparam logic [7:0] CH_LO_G = 8'h67;
  localparam logic [7:0] CH_LO_T = 8'h74;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_DASH = 8'h2D;

  typedef enum logic [1:0] {
    CMD_ANCESTOR = 2'd0,
    CMD_BEGIN    = 2'd1,
    CMD_CHAR     = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    SEL_MATCH  = 3'd0,
    SEL_INSERT = 3'd1,
    SEL_STATE  = 3'd2,
    SEL_TRANS  = 3'd3,
    SEL_ANC    = 3'd4
  } sel_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_CHAR  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CLS_MATCH  = 2'd0,
    CLS_INSERT = 2'd1,
    CLS_DELETE = 2'd2,
    CLS_NONE   = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_BUSY  = 2'd2
  } st_e;

  // decoded character
  typedef struct packed {
    logic       is_char;
    cls_e       cls;
    logic       base_ok;
    logic [1:0] base;
  } sym_info_t;

  // word in flight between accept and write-back
  typedef struct packed {
    logic                  col_upd;
    cls_e                  cls;
    logic                  base_ok;
    logic [1:0]            base;
    logic                  from_mem;
    sel_e                  sel;
    err_e                  err;
    logic [3:0][OUT_W-1:0] cnt;
  } item_t;

endpackage

FILE: rtl/apc_if.sv
// valid/ready channel interfaces for command words and result words
`timescale 1ns / 1ps

interface apc_in_if import apc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] symbol;
  logic [9:0] start_column;
  logic [2:0] table_select;
  logic [9:0] read_index;

  modport source (
    output valid, command, symbol, start_column, table_select, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, symbol, start_column, table_select, read_index,
    output ready
  );
endinterface

interface apc_out_if import apc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] count_0;
  logic [OUT_W-1:0] count_1;
  logic [OUT_W-1:0] count_2;
  logic [OUT_W-1:0] count_3;
  logic [1:0]       error_code;

  modport source (
    output valid, count_0, count_1, count_2, count_3, error_code,
    input  ready
  );
  modport sink (
    input  valid, count_0, count_1, count_2, count_3, error_code,
    output ready
  );
endinterface

FILE: rtl/apc_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`timescale 1ns / 1ps

module apc_ram #(
  parameter int WIDTH = 176,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/apc_sym_decode.sv
// character classifier: state class and base code of one ascii symbol
`timescale 1ns / 1ps

module apc_sym_decode import apc_pkg::*; (
  input  logic [7:0] symbol_i,
  output sym_info_t  info_o
);

  always_comb begin
    info_o = '0;
    // state class
    if (symbol_i >= CH_UP_A && symbol_i <= CH_UP_Z) begin
      info_o.is_char = 1'b1;
      info_o.cls     = CLS_MATCH;
    end else if (symbol_i >= CH_LO_A && symbol_i <= CH_LO_Z) begin
      info_o.is_char = 1'b1;
      info_o.cls     = CLS_INSERT;
    end else if (symbol_i == CH_DASH) begin
      info_o.is_char = 1'b1;
      info_o.cls     = CLS_DELETE;
    end else begin
      info_o.is_char = 1'b0;
      info_o.cls     = CLS_NONE;
    end
    // base code, either case
    if (symbol_i == CH_UP_A || symbol_i == CH_LO_A) begin
      info_o.base_ok = 1'b1;
      info_o.base    = 2'd0;
    end else if (symbol_i == CH_UP_C || symbol_i == CH_LO_C) begin
      info_o.base_ok = 1'b1;
      info_o.base    = 2'd1;
    end else if (symbol_i == CH_UP_G || symbol_i == CH_LO_G) begin
      info_o.base_ok = 1'b1;
      info_o.base    = 2'd2;
    end else if (symbol_i == CH_UP_T || symbol_i == CH_LO_T) begin
      info_o.base_ok = 1'b1;
      info_o.base    = 2'd3;
    end
  end

endmodule

FILE: rtl/alignment_profile_counter_top.sv
// top level of the alignment profile counter: column memory, small counters, control
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------------------
//  in_i    | in  | valid / ready | command, symbol, start_column, table_select, read_index
//  out_o   | out | valid / ready | count_0..count_3, error_code
//
// each word: accept in ST_IDLE (column ram read issued), then in ST_BUSY modify and write back
// the column entry while the result word is loaded into the output register.
// one word is in work at a time.
// after reset a clearing pass writes zero to all MAX_COLUMNS entries, one a cycle,
// during which in_i.ready stays low.
// a stalled result holds the word in work until out_o is free; one more word may be
// accepted while a result waits in the output register.
`timescale 1ns / 1ps

module alignment_profile_counter_top import apc_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apc_in_if.sink    in_i,
  apc_out_if.source out_o
);

  localparam int CW      = $clog2(MAX_COLUMNS);
  localparam int CCW_RAW = $clog2(MAX_COLUMNS + 2);
  localparam int CCW     = (CCW_RAW > 10) ? CCW_RAW : 10;
  localparam int MEM_W   = SLOTS * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // saturating increment
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (c == CMAX) ? c : c + 1'b1;
  endfunction

  // count to result width
  function automatic logic [OUT_W-1:0] narrow(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OUT_W-1:0];
  endfunction

  st_e                   state_q, state_d;
  logic [CW-1:0]         clr_q, clr_d;
  logic [CCW-1:0]        col_q, col_d;
  cls_e                  prev_q, prev_d;
  logic [COUNT_BITS-1:0] trans_q [3][3];
  logic [COUNT_BITS-1:0] trans_d [3][3];
  logic [COUNT_BITS-1:0] anc_q [4];
  logic [COUNT_BITS-1:0] anc_d [4];
  item_t                 item_q, item_d;
  logic [CW-1:0]         addr_q, addr_d;
  sym_info_t             sym;

  logic                  in_accept;
  logic                  done;
  logic                  ram_we;
  logic [CW-1:0]         ram_waddr;
  logic [MEM_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [CW-1:0]         ram_raddr;
  logic [MEM_W-1:0]      ram_rdata;
  logic [MEM_W-1:0]      new_entry;
  logic [3:0][OUT_W-1:0] res_cnt;

  logic                  out_valid_q;
  logic [3:0][OUT_W-1:0] out_cnt_q;
  err_e                  out_err_q;

  apc_sym_decode u_dec (
    .symbol_i (in_i.symbol),
    .info_o   (sym)
  );

  apc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // state register and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      prev_q      <= CLS_NONE;
      trans_q     <= '{default: '0};
      anc_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      prev_q  <= prev_d;
      trans_q <= trans_d;
      anc_q   <= anc_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word in work and result payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    addr_q <= addr_d;
    if (done) begin
      out_cnt_q <= res_cnt;
      out_err_q <= item_q.err;
    end
  end

  // next state, handshake and ram write port
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    in_i.ready = 1'b0;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = new_entry;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CW'(MAX_COLUMNS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        done   = !out_valid_q || out_o.ready;
        ram_we = done && item_q.col_upd;
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_accept = in_i.valid && in_i.ready;

  // command decode at accept: small counters, column position, ram read
  always_comb begin
    logic [CCW-1:0] col_nx;
    logic [CCW-1:0] col_m1;
    logic           adv;
    logic           in_rng;
    logic [31:0]    idx_w;
    logic [1:0]     row;
    col_nx    = col_q;
    col_m1    = '0;
    adv       = 1'b0;
    in_rng    = 1'b0;
    idx_w     = 32'(in_i.read_index);
    row       = '0;
    col_d     = col_q;
    prev_d    = prev_q;
    trans_d   = trans_q;
    anc_d     = anc_q;
    item_d    = item_q;
    addr_d    = addr_q;
    ram_re    = 1'b0;
    ram_raddr = idx_w[CW-1:0];
    if (in_accept) begin
      item_d     = '0;
      item_d.cls = CLS_NONE;
      item_d.err = ERR_OK;
      case (cmd_e'(in_i.command))
        CMD_ANCESTOR: begin
          if (sym.base_ok) begin
            for (int k = 0; k < 4; k++) begin
              if (sym.base == 2'(k)) begin
                anc_d[k] = bump(anc_q[k]);
              end
            end
          end else begin
            item_d.err = ERR_CHAR;
          end
        end
        CMD_BEGIN: begin
          col_d  = CCW'(in_i.start_column);
          prev_d = CLS_NONE;
        end
        CMD_CHAR: begin
          if (!sym.is_char) begin
            item_d.err = ERR_CHAR;
          end else begin
            // transition from the previous class of this sequence
            for (int r = 0; r < 3; r++) begin
              for (int c = 0; c < 3; c++) begin
                if (prev_q == cls_e'(r) && sym.cls == cls_e'(c)) begin
                  trans_d[r][c] = bump(trans_q[r][c]);
                end
              end
            end
            prev_d = sym.cls;
            // match and delete advance the column until past the last one
            adv    = (sym.cls != CLS_INSERT) && (32'(col_q) <= 32'(MAX_COLUMNS));
            col_nx = adv ? col_q + 1'b1 : col_q;
            col_d  = col_nx;
            in_rng = (col_nx != '0) && (32'(col_nx) <= 32'(MAX_COLUMNS));
            if (in_rng) begin
              col_m1         = col_nx - 1'b1;
              addr_d         = col_m1[CW-1:0];
              ram_re         = 1'b1;
              ram_raddr      = col_m1[CW-1:0];
              item_d.col_upd = 1'b1;
              item_d.cls     = sym.cls;
              item_d.base_ok = sym.base_ok;
              item_d.base    = sym.base;
            end else begin
              item_d.err = ERR_RANGE;
            end
          end
        end
        CMD_READ: begin
          case (sel_e'(in_i.table_select))
            SEL_MATCH, SEL_INSERT, SEL_STATE: begin
              if (idx_w >= 32'(MAX_COLUMNS)) begin
                item_d.err = ERR_RANGE;
              end else begin
                ram_re          = 1'b1;
                item_d.from_mem = 1'b1;
                item_d.sel      = sel_e'(in_i.table_select);
              end
            end
            SEL_TRANS: begin
              if (idx_w > 32'd2) begin
                item_d.err = ERR_RANGE;
              end else begin
                row = idx_w[1:0];
                for (int k = 0; k < 3; k++) begin
                  item_d.cnt[k] = narrow(trans_q[row][k]);
                end
              end
            end
            SEL_ANC: begin
              for (int k = 0; k < 4; k++) begin
                item_d.cnt[k] = narrow(anc_q[k]);
              end
            end
            default: begin
              item_d.err = ERR_RANGE;
            end
          endcase
        end
        default: begin
          item_d.err = ERR_RANGE;
        end
      endcase
    end
  end

  // column entry update: state count and base count of the character
  always_comb begin
    logic hit;
    new_entry = ram_rdata;
    for (int s = 0; s < SLOTS; s++) begin
      hit = item_q.col_upd &&
            ((s == SLOT_STATE + int'(item_q.cls)) ||
             (item_q.base_ok && item_q.cls == CLS_MATCH &&
              s == SLOT_MATCH + int'(item_q.base)) ||
             (item_q.base_ok && item_q.cls == CLS_INSERT &&
              s == SLOT_INSERT + int'(item_q.base)));
      if (hit) begin
        new_entry[s*COUNT_BITS +: COUNT_BITS] = bump(ram_rdata[s*COUNT_BITS +: COUNT_BITS]);
      end
    end
  end

  // result counts
  always_comb begin
    res_cnt = item_q.cnt;
    if (item_q.from_mem) begin
      res_cnt = '0;
      case (item_q.sel)
        SEL_MATCH: begin
          for (int k = 0; k < 4; k++) begin
            res_cnt[k] = narrow(ram_rdata[(SLOT_MATCH+k)*COUNT_BITS +: COUNT_BITS]);
          end
        end
        SEL_INSERT: begin
          for (int k = 0; k < 4; k++) begin
            res_cnt[k] = narrow(ram_rdata[(SLOT_INSERT+k)*COUNT_BITS +: COUNT_BITS]);
          end
        end
        SEL_STATE: begin
          for (int k = 0; k < 3; k++) begin
            res_cnt[k] = narrow(ram_rdata[(SLOT_STATE+k)*COUNT_BITS +: COUNT_BITS]);
          end
        end
        default: begin
          res_cnt = '0;
        end
      endcase
    end
  end

  // result channel
  assign out_o.valid      = out_valid_q;
  assign out_o.count_0    = out_cnt_q[0];
  assign out_o.count_1    = out_cnt_q[1];
  assign out_o.count_2    = out_cnt_q[2];
  assign out_o.count_3    = out_cnt_q[3];
  assign out_o.error_code = out_err_q;

endmodule
